/* rtl/core/kdg_pkg.sv */
// ----------------------------------------------------------------------------
// kdg_pkg
// Shared widths, codes and types for the knob dead-zone gate.
// ----------------------------------------------------------------------------
package kdg_pkg;

    localparam int DELTA_W    = 11;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 18;
    localparam int TIMEOUT_W  = 16;
    localparam int COUNT_W    = 8;
    localparam int LEVEL_W    = 19;
    localparam int NET_W      = 12;
    localparam int PEND_W     = 17;
    localparam int KNOB_W     = 12;
    localparam int CC_W       = 7;
    localparam int SCALED_W   = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 32;

    // unlock level is kept in counts times this step
    localparam int LEVEL_STEP = 5000;
    localparam int CC_FULL    = 16383;
    localparam int PEND_MAX   = 65535;
    localparam int PEND_MIN   = -65536;

    localparam logic [COUNT_W-1:0] RUN_MAX = 8'd255;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TIMEOUT_MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_MOVE_COUNTS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUM_LIMIT      = 3'd4;

    typedef struct packed {
        logic [THR_W-1:0]     unlock_threshold;
        logic [TIMEOUT_W-1:0] pause_timeout_ms;
        logic [COUNT_W-1:0]   net_move_counts;
        logic [COUNT_W-1:0]   min_run;
        logic [THR_W-1:0]     accum_limit;
    } cfg_t;

    typedef struct packed {
        logic sent;
        logic unlocked;
    } flags_t;

endpackage

/* rtl/core/kdg_gate.sv */
// ----------------------------------------------------------------------------
// kdg_gate
// Gate state and per-word update: unlock level, run tracking, lock/unlock,
// buffered travel and clamped position.
// ----------------------------------------------------------------------------
module kdg_gate #(
    parameter int MAX_POSITION = 4095,
    parameter int HW           = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  kdg_pkg::cfg_t                         cfg,
    input  logic                                  advance,
    input  logic signed [kdg_pkg::DELTA_W-1:0]    knob_delta,
    input  logic [kdg_pkg::TIME_W-1:0]            now_ms,
    input  logic [kdg_pkg::TIME_W-1:0]            now_us,
    output kdg_pkg::flags_t                       flags,
    output logic [HW-1:0]                         held
);
    import kdg_pkg::*;

    localparam int SUM_W  = 25;
    localparam int POS_W  = HW + 19;
    localparam int PSUM_W = PEND_W + 1;

    logic                       locked_reg, locked_next;
    logic [TIME_W-1:0]          last_ms_reg, last_ms_next;
    logic signed [NET_W-1:0]    net_reg, net_next;
    logic signed [LEVEL_W-1:0]  level_reg, level_next;
    logic [COUNT_W-1:0]         run_len_reg, run_len_next;
    logic [1:0]                 run_dir_reg, run_dir_next;
    logic signed [PEND_W-1:0]   pend_reg, pend_next;
    logic [HW-1:0]              held_reg, held_next;
    logic [TIME_W-1:0]          prev_us_reg;
    logic                       sent_reg, sent_next;

    always_comb begin
        logic signed [SUM_W-1:0]   sum;
        logic signed [SUM_W-1:0]   lim;
        logic signed [LEVEL_W-1:0] lvl;
        logic [THR_W-1:0]          lvl_mag;
        logic [1:0]                dir_in;
        logic                      unlock_hit;
        logic signed [PSUM_W-1:0]  psum;
        logic signed [NET_W-1:0]   net_sum;
        logic [NET_W-1:0]          net_mag;
        logic                      moved;
        logic [TIME_W-1:0]         last_u;
        logic signed [POS_W-1:0]   pos;
        logic [HW-1:0]             pos_c;
        logic [TIME_W-1:0]         elapsed;
        logic [THR_W-1:0]          dec_mag;
        logic [THR_W-1:0]          dec_rem;

        locked_next  = locked_reg;
        last_ms_next = last_ms_reg;
        net_next     = net_reg;
        run_len_next = run_len_reg;
        run_dir_next = run_dir_reg;
        pend_next    = pend_reg;
        held_next    = held_reg;
        sent_next    = 1'b0;

        // accumulate and clamp the unlock level
        sum = SUM_W'(level_reg) + SUM_W'(knob_delta) * SUM_W'(LEVEL_STEP);
        lim = SUM_W'($signed({1'b0, cfg.accum_limit}));
        if (sum > lim) begin
            sum = lim;
        end else if (sum < -lim) begin
            sum = -lim;
        end
        lvl     = LEVEL_W'(sum);
        lvl_mag = (lvl < 0) ? THR_W'(-lvl) : THR_W'(lvl);

        // same-direction run
        dir_in = (knob_delta > 0) ? DIR_POS : DIR_NEG;
        if (knob_delta != 0) begin
            if (dir_in == run_dir_reg) begin
                if (run_len_reg != RUN_MAX) begin
                    run_len_next = run_len_reg + 1'b1;
                end
            end else begin
                run_dir_next = dir_in;
                run_len_next = COUNT_W'(1);
            end
        end

        unlock_hit = (lvl_mag > cfg.unlock_threshold) && (run_len_next >= cfg.min_run);
        psum       = PSUM_W'(pend_reg) + PSUM_W'(knob_delta);
        net_sum    = net_reg + NET_W'(knob_delta);
        net_mag    = (net_sum < 0) ? NET_W'(-net_sum) : NET_W'(net_sum);
        moved      = net_mag >= NET_W'(cfg.net_move_counts);
        last_u     = moved ? now_ms : last_ms_reg;

        if (locked_reg) begin
            if (unlock_hit) begin
                locked_next  = 1'b0;
                last_ms_next = now_ms;
                net_next     = '0;
                lvl          = '0;
                run_len_next = '0;
                run_dir_next = DIR_NONE;
            end else if (psum > PSUM_W'(PEND_MAX)) begin
                pend_next = PEND_W'(PEND_MAX);
            end else if (psum < PSUM_W'(PEND_MIN)) begin
                pend_next = PEND_W'(PEND_MIN);
            end else begin
                pend_next = PEND_W'(psum);
            end
        end else begin
            net_next     = moved ? '0 : net_sum;
            last_ms_next = last_u;
            // relock after a pause
            if ((now_ms - last_u) > TIME_W'(cfg.pause_timeout_ms)) begin
                locked_next  = 1'b1;
                pend_next    = '0;
                net_next     = '0;
                lvl          = '0;
                run_len_next = '0;
                run_dir_next = DIR_NONE;
            end
        end

        // apply travel to the position while open
        pos = POS_W'($signed({1'b0, held_reg})) + POS_W'(knob_delta) + POS_W'(pend_next);
        if (pos < 0) begin
            pos_c = '0;
        end else if (pos > POS_W'(MAX_POSITION)) begin
            pos_c = HW'(MAX_POSITION);
        end else begin
            pos_c = HW'(pos);
        end
        if (!locked_next) begin
            pend_next = '0;
            if (pos_c != held_reg) begin
                held_next = pos_c;
                sent_next = 1'b1;
            end
        end

        // decay towards zero by the elapsed microseconds
        elapsed = now_us - prev_us_reg;
        dec_mag = (lvl < 0) ? THR_W'(-lvl) : THR_W'(lvl);
        dec_rem = dec_mag - THR_W'(elapsed);
        if (TIME_W'(dec_mag) <= elapsed) begin
            level_next = '0;
        end else if (lvl < 0) begin
            level_next = -LEVEL_W'($signed({1'b0, dec_rem}));
        end else begin
            level_next = LEVEL_W'($signed({1'b0, dec_rem}));
        end
        if (level_next == 0) begin
            run_len_next = '0;
            run_dir_next = DIR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg  <= 1'b1;
            last_ms_reg <= '0;
            net_reg     <= '0;
            level_reg   <= '0;
            run_len_reg <= '0;
            run_dir_reg <= DIR_NONE;
            pend_reg    <= '0;
            held_reg    <= '0;
            prev_us_reg <= '0;
        end else if (advance) begin
            locked_reg  <= locked_next;
            last_ms_reg <= last_ms_next;
            net_reg     <= net_next;
            level_reg   <= level_next;
            run_len_reg <= run_len_next;
            run_dir_reg <= run_dir_next;
            pend_reg    <= pend_next;
            held_reg    <= held_next;
            prev_us_reg <= now_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sent_reg <= sent_next;
        end
    end

    // state registers double as the result of the word just taken
    assign flags.sent     = sent_reg;
    assign flags.unlocked = !locked_reg;
    assign held           = held_reg;

endmodule

/* rtl/core/kdg_scale.sv */
// ----------------------------------------------------------------------------
// kdg_scale
// Output stage: scales the position to 0..16383 by a reciprocal multiply and
// holds the result word.
// ----------------------------------------------------------------------------
module kdg_scale #(
    parameter int MAX_POSITION = 4095,
    parameter int HW           = 12
) (
    input  logic                               aclk,
    input  logic                               load,
    input  kdg_pkg::flags_t                    flags_in,
    input  logic [HW-1:0]                      held_in,
    output kdg_pkg::flags_t                    flags_out,
    output logic [kdg_pkg::KNOB_W-1:0]         knob_value,
    output logic [kdg_pkg::CC_W-1:0]           cc_msb,
    output logic [kdg_pkg::CC_W-1:0]           cc_lsb
);
    import kdg_pkg::*;

    // x = held * 16383 fits in N bits; ceil(2^S / MAX) makes the quotient exact
    localparam int N     = HW + SCALED_W;
    localparam int L     = $clog2(MAX_POSITION);
    localparam int S     = N + L;
    localparam int MUL_W = N + 1;
    localparam int PROD_W = N + MUL_W;
    localparam longint unsigned MUL =
        ((64'd1 << S) + longint'(MAX_POSITION) - 1) / longint'(MAX_POSITION);

    logic [N-1:0]        prod_x;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled_reg;
    flags_t              flags_reg;
    logic [HW-1:0]       held_reg;

    assign prod_x = (N'(held_in) << SCALED_W) - N'(held_in);
    assign prod   = PROD_W'(prod_x) * PROD_W'(MUL_W'(MUL));

    always_ff @(posedge aclk) begin
        if (load) begin
            scaled_reg <= prod[S +: SCALED_W];
            flags_reg  <= flags_in;
            held_reg   <= held_in;
        end
    end

    assign flags_out  = flags_reg;
    assign knob_value = KNOB_W'(held_reg);
    assign cc_msb     = scaled_reg[SCALED_W-1:CC_W];
    assign cc_lsb     = scaled_reg[CC_W-1:0];

endmodule

/* rtl/core/knob_deadzone_gate.sv */
// ----------------------------------------------------------------------------
// knob_deadzone_gate
// Dead-zone gate for an endless knob: turns movement deltas into clamped
// position updates and 14-bit controller values.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per knob sample (delta and two timestamps).
//   m_ channel: one word per sample with sent/unlocked flags, the held
//   position and the 14-bit controller value split into two 7-bit halves.
//   cfg_ channel: register writes, always ready; write only while idle.
//   Path: a word accepted on s_ passes the input register, the gate update
//   and the scaling multiply into the output register before it reaches m_.
//   Throughput: one word per cycle; each stage holds one word, so a sample
//   can be taken every cycle while the output keeps moving.
//   When m_tready is low the output word holds and the two stages behind it
//   still fill; s_tready drops once all three are occupied.
//   Reset (aresetn low, synchronous) empties the pipeline, locks the gate,
//   clears position and tracking state and loads the register defaults.
// ----------------------------------------------------------------------------
module knob_deadzone_gate #(
    parameter int MAX_POSITION = 4095
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // knob_delta[10:0], now_ms[42:11], now_us[74:43], zero pad
    input  logic [kdg_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sent[0], unlocked[1], knob_value[13:2], cc_msb[20:14], cc_lsb[27:21], zero pad
    output logic [kdg_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kdg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kdg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kdg_pkg::*;

    localparam int HW = $clog2(MAX_POSITION + 1);

    cfg_t                       cfg_reg;
    logic                       in_valid_reg;
    logic                       mid_valid_reg;
    logic                       out_valid_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic [TIME_W-1:0]          now_ms_reg;
    logic [TIME_W-1:0]          now_us_reg;
    logic                       out_en;
    logic                       mid_en;
    logic                       in_en;
    flags_t                     gate_flags;
    flags_t                     out_flags;
    logic [HW-1:0]              gate_held;
    logic [KNOB_W-1:0]          knob_value;
    logic [CC_W-1:0]            cc_msb;
    logic [CC_W-1:0]            cc_lsb;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unlock_threshold <= THR_W'(5000);
            cfg_reg.pause_timeout_ms <= TIMEOUT_W'(300);
            cfg_reg.net_move_counts  <= COUNT_W'(1);
            cfg_reg.min_run          <= COUNT_W'(3);
            cfg_reg.accum_limit      <= THR_W'(200000);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_UNLOCK_THRESHOLD: cfg_reg.unlock_threshold <= cfg_data[THR_W-1:0];
                CFG_PAUSE_TIMEOUT_MS: cfg_reg.pause_timeout_ms <= cfg_data[TIMEOUT_W-1:0];
                CFG_NET_MOVE_COUNTS:  cfg_reg.net_move_counts  <= cfg_data[COUNT_W-1:0];
                CFG_MIN_RUN:          cfg_reg.min_run          <= cfg_data[COUNT_W-1:0];
                CFG_ACCUM_LIMIT:      cfg_reg.accum_limit      <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage advances when it is empty or the one after it advances
    assign out_en   = !out_valid_reg || m_tready;
    assign mid_en   = !mid_valid_reg || out_en;
    assign in_en    = !in_valid_reg || mid_en;
    assign s_tready = in_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_en) begin
                in_valid_reg <= s_tvalid;
            end
            if (mid_en) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_en) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && s_tvalid) begin
            delta_reg  <= s_tdata[DELTA_W-1:0];
            now_ms_reg <= s_tdata[DELTA_W +: TIME_W];
            now_us_reg <= s_tdata[DELTA_W+TIME_W +: TIME_W];
        end
    end

    kdg_gate #(
        .MAX_POSITION (MAX_POSITION),
        .HW           (HW)
    ) u_gate (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .advance    (mid_en && in_valid_reg),
        .knob_delta (delta_reg),
        .now_ms     (now_ms_reg),
        .now_us     (now_us_reg),
        .flags      (gate_flags),
        .held       (gate_held)
    );

    kdg_scale #(
        .MAX_POSITION (MAX_POSITION),
        .HW           (HW)
    ) u_scale (
        .aclk       (aclk),
        .load       (out_en && mid_valid_reg),
        .flags_in   (gate_flags),
        .held_in    (gate_held),
        .flags_out  (out_flags),
        .knob_value (knob_value),
        .cc_msb     (cc_msb),
        .cc_lsb     (cc_lsb)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, cc_lsb, cc_msb, knob_value, out_flags.unlocked, out_flags.sent};

endmodule

/* rtl/core/kdg_checker.sv */
// ----------------------------------------------------------------------------
// kdg_checker
// Port-level checks for the knob dead-zone gate, bound to the top level.
// ----------------------------------------------------------------------------
module kdg_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tready,
    input  logic [kdg_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // a word is only sent with the gate open
    a_sent_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("sent reported with gate locked");

    // an empty output stage never blocks the input
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind knob_deadzone_gate kdg_checker u_kdg_checker (.*);
